// ----- sv/gacr_pkg.sv -----
// shared types and constants of the gerber arc center resolver
package gacr_pkg;

    // candidate centers in search order: sign of the x offset, sign of the y offset
    typedef logic [1:0] quad_t;

    localparam quad_t QUAD_PP = 2'd0;
    localparam quad_t QUAD_MP = 2'd1;
    localparam quad_t QUAD_MM = 2'd2;
    localparam quad_t QUAD_PM = 2'd3;

    localparam logic MODE_SINGLE = 1'b0;
    localparam logic MODE_MULTI  = 1'b1;

    // width of the result coordinates
    localparam int OUT_W = 32;

    // lanes of the squaring unit
    localparam int SQ_DXP   = 0;
    localparam int SQ_DXM   = 1;
    localparam int SQ_DYP   = 2;
    localparam int SQ_DYM   = 3;
    localparam int SQ_AX    = 4;
    localparam int SQ_AY    = 5;
    localparam int SQ_COUNT = 6;

endpackage

// ----- sv/gacr_arc_if.sv -----
// arc channel: start, end, center offsets and interpolation mode
interface gacr_arc_if #(
    parameter int COORD_BITS = 31
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] offset_x;
    logic signed [COORD_BITS-1:0] offset_y;
    logic                         mode;

    modport source (
        output valid, start_x, start_y, end_x, end_y, offset_x, offset_y, mode,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, end_x, end_y, offset_x, offset_y, mode,
        output ready
    );
endinterface

// ----- sv/gacr_center_if.sv -----
// center channel: resolved arc center and chosen candidate
interface gacr_center_if;
    logic                            valid;
    logic                            ready;
    logic signed [gacr_pkg::OUT_W-1:0] center_x;
    logic signed [gacr_pkg::OUT_W-1:0] center_y;
    gacr_pkg::quad_t                 quadrant_used;

    modport source (
        output valid, center_x, center_y, quadrant_used,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, quadrant_used,
        output ready
    );
endinterface

// ----- sv/gacr_diff.sv -----
// front stages: offset magnitudes, candidate centers and distances to the end point
module gacr_diff #(
    parameter int COORD_BITS = 31
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] offset_x,
    input  logic signed [COORD_BITS-1:0] offset_y,
    input  logic                         mode,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS:0]   cand_xp,
    output logic signed [COORD_BITS:0]   cand_xm,
    output logic signed [COORD_BITS:0]   cand_yp,
    output logic signed [COORD_BITS:0]   cand_ym,
    output logic        [COORD_BITS:0]   dist_xp,
    output logic        [COORD_BITS:0]   dist_xm,
    output logic        [COORD_BITS:0]   dist_yp,
    output logic        [COORD_BITS:0]   dist_ym,
    output logic        [COORD_BITS-1:0] mag_x,
    output logic        [COORD_BITS-1:0] mag_y,
    output logic                         mode_out
);

    localparam int CW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 2;

    // |c - e|, which always fits in one bit above the coordinate width
    function automatic logic [CW-1:0] dist_f(
        input logic signed [CW-1:0]         c,
        input logic signed [COORD_BITS-1:0] e
    );
        logic signed [DW-1:0] p;
        logic signed [DW-1:0] n;
        p = DW'(c) - DW'(e);
        n = DW'(e) - DW'(c);
        return p[DW-1] ? n[CW-1:0] : p[CW-1:0];
    endfunction

    logic                         ready_a;
    logic                         ready_b;

    // stage a
    logic                         v_a_reg;
    logic                         v_a_next;
    logic        [COORD_BITS-1:0] ax_next;
    logic        [COORD_BITS-1:0] ay_next;
    logic signed [CW-1:0]         sx_e;
    logic signed [CW-1:0]         sy_e;
    logic signed [CW-1:0]         ox_e;
    logic signed [CW-1:0]         oy_e;
    logic signed [CW-1:0]         ax_e;
    logic signed [CW-1:0]         ay_e;
    logic signed [CW-1:0]         cxp_next;
    logic signed [CW-1:0]         cxm_next;
    logic signed [CW-1:0]         cyp_next;
    logic signed [CW-1:0]         cym_next;
    logic signed [CW-1:0]         cxp_a_reg;
    logic signed [CW-1:0]         cxm_a_reg;
    logic signed [CW-1:0]         cyp_a_reg;
    logic signed [CW-1:0]         cym_a_reg;
    logic signed [COORD_BITS-1:0] ex_a_reg;
    logic signed [COORD_BITS-1:0] ey_a_reg;
    logic        [COORD_BITS-1:0] ax_a_reg;
    logic        [COORD_BITS-1:0] ay_a_reg;
    logic                         mode_a_reg;

    // stage b
    logic                         v_b_reg;
    logic                         v_b_next;
    logic signed [CW-1:0]         cxp_b_reg;
    logic signed [CW-1:0]         cxm_b_reg;
    logic signed [CW-1:0]         cyp_b_reg;
    logic signed [CW-1:0]         cym_b_reg;
    logic        [CW-1:0]         dxp_b_reg;
    logic        [CW-1:0]         dxm_b_reg;
    logic        [CW-1:0]         dyp_b_reg;
    logic        [CW-1:0]         dym_b_reg;
    logic        [COORD_BITS-1:0] ax_b_reg;
    logic        [COORD_BITS-1:0] ay_b_reg;
    logic                         mode_b_reg;

    assign ready_b  = !v_b_reg || out_ready;
    assign ready_a  = !v_a_reg || ready_b;
    assign in_ready = ready_a;

    always_comb
    begin
        // the most negative offset has magnitude 2^(COORD_BITS-1), exact as unsigned
        ax_next  = offset_x[COORD_BITS-1] ? COORD_BITS'(~$unsigned(offset_x) + 1'b1)
                                          : $unsigned(offset_x);
        ay_next  = offset_y[COORD_BITS-1] ? COORD_BITS'(~$unsigned(offset_y) + 1'b1)
                                          : $unsigned(offset_y);
        sx_e     = CW'(start_x);
        sy_e     = CW'(start_y);
        ox_e     = CW'(offset_x);
        oy_e     = CW'(offset_y);
        ax_e     = signed'({1'b0, ax_next});
        ay_e     = signed'({1'b0, ay_next});
        // multi-quadrant center rides in the first candidate slot
        cxp_next = (mode == gacr_pkg::MODE_MULTI) ? sx_e + ox_e : sx_e + ax_e;
        cyp_next = (mode == gacr_pkg::MODE_MULTI) ? sy_e + oy_e : sy_e + ay_e;
        cxm_next = sx_e - ax_e;
        cym_next = sy_e - ay_e;
        v_a_next = ready_a ? in_valid : v_a_reg;
        v_b_next = ready_b ? v_a_reg : v_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
        end
        else
        begin
            v_a_reg <= v_a_next;
            v_b_reg <= v_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a)
        begin
            cxp_a_reg  <= cxp_next;
            cxm_a_reg  <= cxm_next;
            cyp_a_reg  <= cyp_next;
            cym_a_reg  <= cym_next;
            ex_a_reg   <= end_x;
            ey_a_reg   <= end_y;
            ax_a_reg   <= ax_next;
            ay_a_reg   <= ay_next;
            mode_a_reg <= mode;
        end
        if (ready_b)
        begin
            cxp_b_reg  <= cxp_a_reg;
            cxm_b_reg  <= cxm_a_reg;
            cyp_b_reg  <= cyp_a_reg;
            cym_b_reg  <= cym_a_reg;
            dxp_b_reg  <= dist_f(cxp_a_reg, ex_a_reg);
            dxm_b_reg  <= dist_f(cxm_a_reg, ex_a_reg);
            dyp_b_reg  <= dist_f(cyp_a_reg, ey_a_reg);
            dym_b_reg  <= dist_f(cym_a_reg, ey_a_reg);
            ax_b_reg   <= ax_a_reg;
            ay_b_reg   <= ay_a_reg;
            mode_b_reg <= mode_a_reg;
        end
    end

    assign out_valid = v_b_reg;
    assign cand_xp   = cxp_b_reg;
    assign cand_xm   = cxm_b_reg;
    assign cand_yp   = cyp_b_reg;
    assign cand_ym   = cym_b_reg;
    assign dist_xp   = dxp_b_reg;
    assign dist_xm   = dxm_b_reg;
    assign dist_yp   = dyp_b_reg;
    assign dist_ym   = dym_b_reg;
    assign mag_x     = ax_b_reg;
    assign mag_y     = ay_b_reg;
    assign mode_out  = mode_b_reg;

endmodule

// ----- sv/gacr_square.sv -----
// two-stage squaring unit: half-width partial products, then assembly
module gacr_square #(
    parameter int W      = 32,
    parameter int N      = 6,
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [N-1:0][W-1:0]       val,
    input  logic [SIDE_W-1:0]         side,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [N-1:0][2*W-1:0]     sq,
    output logic [SIDE_W-1:0]         side_out
);

    localparam int LO_W = (W + 1) / 2;
    localparam int HI_W = W - LO_W;

    logic                             ready_p;
    logic                             ready_q;

    logic                             v_p_reg;
    logic                             v_p_next;
    logic [N-1:0][2*LO_W-1:0]         ll_next;
    logic [N-1:0][HI_W+LO_W-1:0]      hl_next;
    logic [N-1:0][2*HI_W-1:0]         hh_next;
    logic [N-1:0][2*LO_W-1:0]         ll_p_reg;
    logic [N-1:0][HI_W+LO_W-1:0]      hl_p_reg;
    logic [N-1:0][2*HI_W-1:0]         hh_p_reg;
    logic [SIDE_W-1:0]                side_p_reg;

    logic                             v_q_reg;
    logic                             v_q_next;
    logic [N-1:0][2*W-1:0]            sq_next;
    logic [N-1:0][2*W-1:0]            sq_q_reg;
    logic [SIDE_W-1:0]                side_q_reg;

    assign ready_q  = !v_q_reg || out_ready;
    assign ready_p  = !v_p_reg || ready_q;
    assign in_ready = ready_p;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            ll_next[i] = val[i][LO_W-1:0] * val[i][LO_W-1:0];
            hl_next[i] = val[i][W-1:LO_W] * val[i][LO_W-1:0];
            hh_next[i] = val[i][W-1:LO_W] * val[i][W-1:LO_W];
        end
        // x^2 = hi^2 << 2L  +  2 hi lo << L  +  lo^2
        for (int i = 0; i < N; i++)
        begin
            sq_next[i] = {hh_p_reg[i], ll_p_reg[i]}
                       + ((2*W)'(hl_p_reg[i]) << (LO_W + 1));
        end
        v_p_next = ready_p ? in_valid : v_p_reg;
        v_q_next = ready_q ? v_p_reg : v_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_p_reg <= 1'b0;
            v_q_reg <= 1'b0;
        end
        else
        begin
            v_p_reg <= v_p_next;
            v_q_reg <= v_q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_p)
        begin
            ll_p_reg   <= ll_next;
            hl_p_reg   <= hl_next;
            hh_p_reg   <= hh_next;
            side_p_reg <= side;
        end
        if (ready_q)
        begin
            sq_q_reg   <= sq_next;
            side_q_reg <= side_p_reg;
        end
    end

    assign out_valid = v_q_reg;
    assign sq        = sq_q_reg;
    assign side_out  = side_q_reg;

endmodule

// ----- sv/gacr_pick.sv -----
// back stages: squared radii, mismatches, tie-safe minimum search and center select
module gacr_pick #(
    parameter int COORD_BITS = 31
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [gacr_pkg::SQ_COUNT-1:0][2*COORD_BITS+1:0] sq,
    // {mode, cand_ym, cand_yp, cand_xm, cand_xp}
    input  logic [4*(COORD_BITS+1):0]                     side,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic signed [gacr_pkg::OUT_W-1:0]             center_x,
    output logic signed [gacr_pkg::OUT_W-1:0]             center_y,
    output gacr_pkg::quad_t                               quadrant_used
);

    localparam int CW     = COORD_BITS + 1;
    localparam int MW     = 2 * CW + 1;
    localparam int SIDE_W = 4 * CW + 1;
    localparam int EW     = (CW > gacr_pkg::OUT_W) ? CW : gacr_pkg::OUT_W;

    logic                        ready_c;
    logic                        ready_d;
    logic                        ready_e;
    logic                        ready_f;

    // stage c: squared distances and squared radius
    logic                        v_c_reg;
    logic                        v_c_next;
    logic [3:0][MW-1:0]          d2_next;
    logic [MW-1:0]               r2_next;
    logic [3:0][MW-1:0]          d2_c_reg;
    logic [MW-1:0]               r2_c_reg;
    logic [SIDE_W-1:0]           side_c_reg;

    // stage d: mismatches
    logic                        v_d_reg;
    logic                        v_d_next;
    logic [3:0][MW-1:0]          mis_next;
    logic [3:0][MW:0]            dr_diff;
    logic [3:0][MW-1:0]          mis_d_reg;
    logic [SIDE_W-1:0]           side_d_reg;

    // stage e: pairwise minimum
    logic                        v_e_reg;
    logic                        v_e_next;
    logic [MW-1:0]               min01_e_reg;
    logic [MW-1:0]               min23_e_reg;
    gacr_pkg::quad_t             idx01_e_reg;
    gacr_pkg::quad_t             idx23_e_reg;
    logic [SIDE_W-1:0]           side_e_reg;

    // stage f: output register
    logic                        v_f_reg;
    logic                        v_f_next;
    gacr_pkg::quad_t             best;
    gacr_pkg::quad_t             quad_next;
    logic signed [CW-1:0]        cxp_e;
    logic signed [CW-1:0]        cxm_e;
    logic signed [CW-1:0]        cyp_e;
    logic signed [CW-1:0]        cym_e;
    logic                        mode_e;
    logic signed [CW-1:0]        sel_x;
    logic signed [CW-1:0]        sel_y;
    logic signed [EW-1:0]        wide_x;
    logic signed [EW-1:0]        wide_y;
    gacr_pkg::quad_t             quad_f_reg;
    logic [gacr_pkg::OUT_W-1:0]  cx_f_reg;
    logic [gacr_pkg::OUT_W-1:0]  cy_f_reg;

    assign ready_f  = !v_f_reg || out_ready;
    assign ready_e  = !v_e_reg || ready_f;
    assign ready_d  = !v_d_reg || ready_e;
    assign ready_c  = !v_c_reg || ready_d;
    assign in_ready = ready_c;

    always_comb
    begin
        d2_next[gacr_pkg::QUAD_PP] = MW'(sq[gacr_pkg::SQ_DXP]) + MW'(sq[gacr_pkg::SQ_DYP]);
        d2_next[gacr_pkg::QUAD_MP] = MW'(sq[gacr_pkg::SQ_DXM]) + MW'(sq[gacr_pkg::SQ_DYP]);
        d2_next[gacr_pkg::QUAD_MM] = MW'(sq[gacr_pkg::SQ_DXM]) + MW'(sq[gacr_pkg::SQ_DYM]);
        d2_next[gacr_pkg::QUAD_PM] = MW'(sq[gacr_pkg::SQ_DXP]) + MW'(sq[gacr_pkg::SQ_DYM]);
        r2_next = MW'(sq[gacr_pkg::SQ_AX]) + MW'(sq[gacr_pkg::SQ_AY]);

        // borrow of d2 - r2 picks the direction of the absolute difference
        for (int k = 0; k < 4; k++)
        begin
            dr_diff[k]  = {1'b0, d2_c_reg[k]} - {1'b0, r2_c_reg};
            mis_next[k] = dr_diff[k][MW] ? (r2_c_reg - d2_c_reg[k]) : dr_diff[k][MW-1:0];
        end

        cxp_e  = side_e_reg[CW-1:0];
        cxm_e  = side_e_reg[2*CW-1:CW];
        cyp_e  = side_e_reg[3*CW-1:2*CW];
        cym_e  = side_e_reg[4*CW-1:3*CW];
        mode_e = side_e_reg[4*CW];

        // strict compare keeps the earlier candidate on a tie
        best      = (min23_e_reg < min01_e_reg) ? idx23_e_reg : idx01_e_reg;
        quad_next = (mode_e == gacr_pkg::MODE_MULTI) ? gacr_pkg::QUAD_PP : best;
        case (quad_next)
            gacr_pkg::QUAD_PP:
            begin
                sel_x = cxp_e;
                sel_y = cyp_e;
            end
            gacr_pkg::QUAD_MP:
            begin
                sel_x = cxm_e;
                sel_y = cyp_e;
            end
            gacr_pkg::QUAD_MM:
            begin
                sel_x = cxm_e;
                sel_y = cym_e;
            end
            gacr_pkg::QUAD_PM:
            begin
                sel_x = cxp_e;
                sel_y = cym_e;
            end
            default:
            begin
                sel_x = cxp_e;
                sel_y = cyp_e;
            end
        endcase
        wide_x = EW'(sel_x);
        wide_y = EW'(sel_y);

        v_c_next = ready_c ? in_valid : v_c_reg;
        v_d_next = ready_d ? v_c_reg : v_d_reg;
        v_e_next = ready_e ? v_d_reg : v_e_reg;
        v_f_next = ready_f ? v_e_reg : v_f_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
            v_e_reg <= 1'b0;
            v_f_reg <= 1'b0;
        end
        else
        begin
            v_c_reg <= v_c_next;
            v_d_reg <= v_d_next;
            v_e_reg <= v_e_next;
            v_f_reg <= v_f_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_c)
        begin
            d2_c_reg   <= d2_next;
            r2_c_reg   <= r2_next;
            side_c_reg <= side;
        end
        if (ready_d)
        begin
            mis_d_reg  <= mis_next;
            side_d_reg <= side_c_reg;
        end
        if (ready_e)
        begin
            if (mis_d_reg[gacr_pkg::QUAD_MP] < mis_d_reg[gacr_pkg::QUAD_PP])
            begin
                min01_e_reg <= mis_d_reg[gacr_pkg::QUAD_MP];
                idx01_e_reg <= gacr_pkg::QUAD_MP;
            end
            else
            begin
                min01_e_reg <= mis_d_reg[gacr_pkg::QUAD_PP];
                idx01_e_reg <= gacr_pkg::QUAD_PP;
            end
            if (mis_d_reg[gacr_pkg::QUAD_PM] < mis_d_reg[gacr_pkg::QUAD_MM])
            begin
                min23_e_reg <= mis_d_reg[gacr_pkg::QUAD_PM];
                idx23_e_reg <= gacr_pkg::QUAD_PM;
            end
            else
            begin
                min23_e_reg <= mis_d_reg[gacr_pkg::QUAD_MM];
                idx23_e_reg <= gacr_pkg::QUAD_MM;
            end
            side_e_reg <= side_d_reg;
        end
        if (ready_f)
        begin
            quad_f_reg <= quad_next;
            cx_f_reg   <= wide_x[gacr_pkg::OUT_W-1:0];
            cy_f_reg   <= wide_y[gacr_pkg::OUT_W-1:0];
        end
    end

    assign out_valid     = v_f_reg;
    assign center_x      = cx_f_reg;
    assign center_y      = cy_f_reg;
    assign quadrant_used = quad_f_reg;

    a_enter_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_c_reg)
        else $error("transfer into the pick stages did not land in the first stage");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v_c_reg && v_d_reg && v_e_reg && v_f_reg)
        else $error("pick stages refuse a transfer while holding a bubble");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v_f_reg && !out_ready |=> v_f_reg && $stable(quad_f_reg) && $stable(cx_f_reg)
                                  && $stable(cy_f_reg))
        else $error("stalled result changed in the output register");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        v_e_reg |-> (idx01_e_reg == gacr_pkg::QUAD_PP || idx01_e_reg == gacr_pkg::QUAD_MP)
                    && (idx23_e_reg == gacr_pkg::QUAD_MM || idx23_e_reg == gacr_pkg::QUAD_PM))
        else $error("pairwise minimum picked a candidate outside its pair");

endmodule

// ----- sv/gerber_arc_center_resolver.sv -----
// top level of the gerber arc center resolver
//
// Takes one arc per transfer on the arc channel (start point, end point, center
// offsets, mode) and returns one center per arc on the center channel, in order.
// Multi-quadrant mode: center = start + signed offsets, quadrant_used = 0.
// Single-quadrant mode: the four sign combinations of the offset magnitudes are
// scored by |squared distance to end - squared offset length| and the lowest wins,
// the earlier candidate on a tie.
// Pipeline: two front stages, two squaring stages, four compare and select stages
// ending in the output register. Throughput: one arc per cycle while the receiver
// takes centers; every stage is a valid/ready register with its own ready, so the
// squaring multipliers and the compare stages all run in parallel.
// When the receiver stalls, stages behind the held result keep filling and arc
// ready drops only once all eight stages are full; nothing is lost or repeated.
// Reset clears the stage valid bits; the block accepts arcs in the first cycle
// after reset is released.
module gerber_arc_center_resolver #(
    parameter int COORD_BITS = 31
) (
    input  logic           clk,
    input  logic           rst_n,
    gacr_arc_if.sink       arc,
    gacr_center_if.source  center
);

    localparam int CW     = COORD_BITS + 1;
    localparam int SIDE_W = 4 * CW + 1;

    logic                                      diff_valid;
    logic                                      diff_ready;
    logic signed [CW-1:0]                      cand_xp;
    logic signed [CW-1:0]                      cand_xm;
    logic signed [CW-1:0]                      cand_yp;
    logic signed [CW-1:0]                      cand_ym;
    logic        [CW-1:0]                      dist_xp;
    logic        [CW-1:0]                      dist_xm;
    logic        [CW-1:0]                      dist_yp;
    logic        [CW-1:0]                      dist_ym;
    logic        [COORD_BITS-1:0]              mag_x;
    logic        [COORD_BITS-1:0]              mag_y;
    logic                                      diff_mode;

    logic [gacr_pkg::SQ_COUNT-1:0][CW-1:0]     sq_val;
    logic [SIDE_W-1:0]                         sq_side;
    logic                                      sq_valid;
    logic                                      sq_ready;
    logic [gacr_pkg::SQ_COUNT-1:0][2*CW-1:0]   sq_res;
    logic [SIDE_W-1:0]                         sq_side_out;

    gacr_diff #(
        .COORD_BITS (COORD_BITS)
    ) u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (arc.valid),
        .in_ready  (arc.ready),
        .start_x   (arc.start_x),
        .start_y   (arc.start_y),
        .end_x     (arc.end_x),
        .end_y     (arc.end_y),
        .offset_x  (arc.offset_x),
        .offset_y  (arc.offset_y),
        .mode      (arc.mode),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .cand_xp   (cand_xp),
        .cand_xm   (cand_xm),
        .cand_yp   (cand_yp),
        .cand_ym   (cand_ym),
        .dist_xp   (dist_xp),
        .dist_xm   (dist_xm),
        .dist_yp   (dist_yp),
        .dist_ym   (dist_ym),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .mode_out  (diff_mode)
    );

    always_comb
    begin
        sq_val[gacr_pkg::SQ_DXP] = dist_xp;
        sq_val[gacr_pkg::SQ_DXM] = dist_xm;
        sq_val[gacr_pkg::SQ_DYP] = dist_yp;
        sq_val[gacr_pkg::SQ_DYM] = dist_ym;
        sq_val[gacr_pkg::SQ_AX]  = CW'(mag_x);
        sq_val[gacr_pkg::SQ_AY]  = CW'(mag_y);
        sq_side = {diff_mode, cand_ym, cand_yp, cand_xm, cand_xp};
    end

    gacr_square #(
        .W      (CW),
        .N      (gacr_pkg::SQ_COUNT),
        .SIDE_W (SIDE_W)
    ) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .val       (sq_val),
        .side      (sq_side),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .sq        (sq_res),
        .side_out  (sq_side_out)
    );

    gacr_pick #(
        .COORD_BITS (COORD_BITS)
    ) u_pick (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (sq_valid),
        .in_ready      (sq_ready),
        .sq            (sq_res),
        .side          (sq_side_out),
        .out_valid     (center.valid),
        .out_ready     (center.ready),
        .center_x      (center.center_x),
        .center_y      (center.center_y),
        .quadrant_used (center.quadrant_used)
    );

endmodule
